/* rtl/cff_dict_token_decoder_assert.svh */
// ----------------------------------------------------------------------------
// CFF DICT token decoder assertion macros
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CFF_DICT_TOKEN_DECODER_ASSERT_SVH
`define CFF_DICT_TOKEN_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CDTD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define CDTD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/cdtd_pkg.sv */
// ----------------------------------------------------------------------------
// CFF DICT token decoder package
// Transfer types, byte codes, parse modes and token kinds.
// ----------------------------------------------------------------------------
package cdtd_pkg;

	localparam int MAX_REAL_NIBBLES = 16;

	// Parse modes.
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_ESC   = 3'd1;
	localparam logic [2:0] MODE_SHORT = 3'd2;
	localparam logic [2:0] MODE_LONG  = 3'd3;
	localparam logic [2:0] MODE_POS   = 3'd4;
	localparam logic [2:0] MODE_NEG   = 3'd5;
	localparam logic [2:0] MODE_REAL  = 3'd6;

	// Token kinds.
	localparam logic [1:0] KIND_OPERATOR  = 2'd0;
	localparam logic [1:0] KIND_INTEGER   = 2'd1;
	localparam logic [1:0] KIND_REAL      = 2'd2;
	localparam logic [1:0] KIND_MALFORMED = 2'd3;

	// DICT byte codes.
	localparam logic [7:0] BYTE_OP_MAX    = 8'd21;
	localparam logic [7:0] BYTE_ESCAPE    = 8'd12;
	localparam logic [7:0] BYTE_SHORT_INT = 8'd28;
	localparam logic [7:0] BYTE_LONG_INT  = 8'd29;
	localparam logic [7:0] BYTE_REAL      = 8'd30;
	localparam logic [7:0] BYTE_INT1_MIN  = 8'd32;
	localparam logic [7:0] BYTE_INT1_MAX  = 8'd246;
	localparam logic [7:0] BYTE_POS_MIN   = 8'd247;
	localparam logic [7:0] BYTE_POS_MAX   = 8'd250;
	localparam logic [7:0] BYTE_NEG_MIN   = 8'd251;
	localparam logic [7:0] BYTE_NEG_MAX   = 8'd254;
	localparam logic [31:0] INT1_BIAS     = 32'd139;
	localparam logic [31:0] INT2_BIAS     = 32'd108;
	localparam logic [3:0] NIBBLE_END     = 4'hf;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]         token_kind;
		logic               escaped_op;
		logic [7:0]         op_code;
		logic signed [31:0] int_value;
		logic [63:0]        real_nibbles;
		logic [4:0]         real_count;
		logic               real_overflow;
		logic               dict_end;
	} token_item_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [1:0]  bytes_left;
		logic [31:0] accum;
		logic [63:0] nibbles;
		logic [4:0]  count;
		logic        overflow;
	} parse_state_t;

	localparam parse_state_t PARSE_IDLE = '{
		mode: MODE_IDLE, bytes_left: 2'd0, accum: 32'd0,
		nibbles: 64'd0, count: 5'd0, overflow: 1'b0
	};

endpackage

/* rtl/cdtd_parser.sv */
// ----------------------------------------------------------------------------
// CFF DICT token decoder parser
// Holds the parse state and decodes one DICT byte into at most one token.
// ----------------------------------------------------------------------------
module cdtd_parser import cdtd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  byte_item_t   item,
	output logic         has_result,
	output token_item_t  result
);

	`include "cff_dict_token_decoder_assert.svh"

	parse_state_t state_q;
	parse_state_t nxt;

	function automatic parse_state_t add_nibble(parse_state_t s, logic [3:0] n);
		parse_state_t r;
		r = s;
		if (s.count < 5'(MAX_REAL_NIBBLES)) begin
			r.nibbles = {s.nibbles[59:0], n};
			r.count   = s.count + 5'd1;
		end else begin
			r.overflow = 1'b1;
		end
		return r;
	endfunction

	logic [7:0]  b;
	logic [3:0]  hi;
	logic [3:0]  lo;
	logic [31:0] acc;
	logic [31:0] two_byte;

	assign b  = item.data_byte;
	assign hi = b[7:4];
	assign lo = b[3:0];
	assign acc = {state_q.accum[23:0], b};
	assign two_byte = {state_q.accum[23:0], 8'd0} + {24'd0, b} + INT2_BIAS;

	always_comb begin
		nxt        = state_q;
		has_result = 1'b0;
		result     = '0;
		result.dict_end = item.last_byte;
		unique case (state_q.mode)
			MODE_IDLE: begin
				if (b <= BYTE_OP_MAX && b != BYTE_ESCAPE) begin
					has_result = 1'b1;
					result.token_kind = KIND_OPERATOR;
					result.op_code = b;
				end else if (b >= BYTE_INT1_MIN && b <= BYTE_INT1_MAX) begin
					has_result = 1'b1;
					result.token_kind = KIND_INTEGER;
					result.int_value = {24'd0, b} - INT1_BIAS;
				end else if (b == BYTE_ESCAPE) begin
					nxt.mode = MODE_ESC;
				end else if (b == BYTE_SHORT_INT) begin
					nxt.mode = MODE_SHORT;
					nxt.bytes_left = 2'd1;
					nxt.accum = 32'd0;
				end else if (b == BYTE_LONG_INT) begin
					nxt.mode = MODE_LONG;
					nxt.bytes_left = 2'd3;
					nxt.accum = 32'd0;
				end else if (b == BYTE_REAL) begin
					nxt.mode = MODE_REAL;
					nxt.nibbles = 64'd0;
					nxt.count = 5'd0;
					nxt.overflow = 1'b0;
				end else if (b >= BYTE_POS_MIN && b <= BYTE_POS_MAX) begin
					nxt.mode = MODE_POS;
					nxt.accum = {24'd0, b - BYTE_POS_MIN};
				end else if (b >= BYTE_NEG_MIN && b <= BYTE_NEG_MAX) begin
					nxt.mode = MODE_NEG;
					nxt.accum = {24'd0, b - BYTE_NEG_MIN};
				end else begin
					has_result = 1'b1;
					result.token_kind = KIND_MALFORMED;
				end
			end
			MODE_ESC: begin
				nxt = PARSE_IDLE;
				has_result = 1'b1;
				result.token_kind = KIND_OPERATOR;
				result.escaped_op = 1'b1;
				result.op_code = b;
			end
			MODE_SHORT, MODE_LONG: begin
				if (state_q.bytes_left == 2'd0) begin
					nxt = PARSE_IDLE;
					has_result = 1'b1;
					result.token_kind = KIND_INTEGER;
					if (state_q.mode == MODE_SHORT) begin
						result.int_value = {{16{acc[15]}}, acc[15:0]};
					end else begin
						result.int_value = acc;
					end
				end else begin
					nxt.accum = acc;
					nxt.bytes_left = state_q.bytes_left - 2'd1;
				end
			end
			MODE_POS: begin
				nxt = PARSE_IDLE;
				has_result = 1'b1;
				result.token_kind = KIND_INTEGER;
				result.int_value = two_byte;
			end
			MODE_NEG: begin
				nxt = PARSE_IDLE;
				has_result = 1'b1;
				result.token_kind = KIND_INTEGER;
				result.int_value = 32'd0 - two_byte;
			end
			MODE_REAL: begin
				if (hi != NIBBLE_END) begin
					nxt = add_nibble(nxt, hi);
					if (lo != NIBBLE_END) begin
						nxt = add_nibble(nxt, lo);
					end
				end
				if (hi == NIBBLE_END || lo == NIBBLE_END) begin
					has_result = 1'b1;
					result.token_kind = KIND_REAL;
					result.real_nibbles = nxt.nibbles;
					result.real_count = nxt.count;
					result.real_overflow = nxt.overflow;
					nxt = PARSE_IDLE;
				end
			end
			default: begin
				nxt = PARSE_IDLE;
			end
		endcase
		// A token still pending on the final byte was cut off.
		if (!has_result && item.last_byte) begin
			nxt = PARSE_IDLE;
			has_result = 1'b1;
			result = '0;
			result.token_kind = KIND_MALFORMED;
			result.dict_end = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_IDLE;
		end else if (fire) begin
			state_q <= nxt;
		end
	end

	`CDTD_ASSERT_IMPLY(a_idle_clean, state_q.mode == MODE_IDLE,
		state_q == PARSE_IDLE, "parser idle with stale state")
	`CDTD_ASSERT_ALWAYS(a_count_bound, state_q.count <= 5'(MAX_REAL_NIBBLES),
		"nibble count past limit")
	`CDTD_ASSERT_IMPLY(a_overflow_full, state_q.overflow,
		state_q.count == 5'(MAX_REAL_NIBBLES), "overflow before store is full")
	`CDTD_ASSERT_IMPLY(a_bytes_left_mode,
		state_q.mode != MODE_SHORT && state_q.mode != MODE_LONG,
		state_q.bytes_left == 2'd0, "bytes left outside integer modes")

endmodule

/* rtl/cff_dict_token_decoder.sv */
// A byte taken is held in the byte register, decoded by the parse step and its token held in
// the token register that drives the outputs; a stalled token register holds the byte back.
// Throughput: one byte per cycle, sustained, while the token side takes transfers.
// The figure is set by the single parse step between the byte register and the token register.
// Reset: arst_n low clears both stage valids and returns the parser to idle at once.
// There is no clearing pass; the block takes a byte in the first cycle after reset.
// ----------------------------------------------------------------------------
// CFF DICT token decoder
// Decodes a CFF DICT byte stream into operator, integer, real and malformed tokens.
// ----------------------------------------------------------------------------
module cff_dict_token_decoder import cdtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  byte_item_t  byte_item,
	output logic        token_valid,
	input  logic        token_stall,
	output token_item_t token_item
);

	// Stage one holds the accepted byte. Stage two holds the finished token.
	logic        byte_valid_s1;
	byte_item_t  byte_item_s1;
	logic        token_valid_s2;
	token_item_t token_item_s2;

	logic        has_result;
	token_item_t result;
	logic        fire;

	// The byte in stage one is consumed when it makes no token, or when the
	// token register is empty or is handing its token over in this cycle.
	// Parse state only moves on that consume, so a stalled byte is held and
	// decoded again against the same state.
	assign fire = byte_valid_s1 && (!has_result || !token_valid_s2 || !token_stall);

	// A new byte is taken whenever stage one is empty or is being consumed,
	// so bytes stream one per cycle while tokens drain.
	assign byte_stall = byte_valid_s1 && !fire;

	cdtd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (byte_item_s1),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			byte_valid_s1 <= 1'b1;
		end else if (fire) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_item_s1 <= byte_item;
		end
	end

	// The token register loads on a consume that makes a token; otherwise it
	// empties once its transfer completes, and holds steady while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_s2 <= 1'b0;
		end else if (fire && has_result) begin
			token_valid_s2 <= 1'b1;
		end else if (!token_stall) begin
			token_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			token_item_s2 <= result;
		end
	end

	assign token_valid = token_valid_s2;
	assign token_item  = token_item_s2;

endmodule

/* tb/sv/tb_cff_dict_token_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CFF DICT token decoder testbench
// Drives DICT byte streams into the decoder, predicts every token from an
// independent parser model and checks each token transfer field by field.
// ----------------------------------------------------------------------------
module tb_cff_dict_token_decoder;
	import cdtd_pkg::*;

	// Reserved DICT bytes that must come back as malformed tokens.
	localparam logic [7:0] BYTE_RSV_LO = 8'd22;
	localparam logic [7:0] BYTE_RSV_HI = 8'd27;
	localparam logic [7:0] BYTE_RSV_31 = 8'd31;
	localparam logic [7:0] BYTE_RSV_FF = 8'hff;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	byte_item_t  byte_item;
	logic        token_valid;
	logic        token_stall;
	token_item_t token_item;

	// Tokens the parser model says must come out, oldest first.
	token_item_t expected_tokens[$];
	token_item_t want;
	int          errors = 0;
	int          bytes_sent = 0;

	// Idling controls shared by the sender, the receiver and the test tasks.
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_len = 0;

	// Parser model state, a private copy of what the decoder keeps.
	logic [2:0]  pm_mode;
	logic [1:0]  pm_left;
	logic [31:0] pm_accum;
	logic [63:0] pm_nibbles;
	logic [4:0]  pm_count;
	logic        pm_overflow;

	cff_dict_token_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the handshake locks up.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Parser model.
	// ------------------------------------------------------------------

	// Every completed or abandoned token drops the parser back to idle with
	// all of its working registers cleared.
	function automatic void parser_to_idle();
		pm_mode     = MODE_IDLE;
		pm_left     = 2'd0;
		pm_accum    = 32'd0;
		pm_nibbles  = 64'd0;
		pm_count    = 5'd0;
		pm_overflow = 1'b0;
	endfunction

	// Nibbles past the capacity are dropped but remembered as an overflow.
	function automatic void keep_nibble(input logic [3:0] nib);
		if (pm_count < MAX_REAL_NIBBLES) begin
			pm_nibbles = {pm_nibbles[59:0], nib};
			pm_count   = pm_count + 5'd1;
		end else begin
			pm_overflow = 1'b1;
		end
	endfunction

	// Advances the parser by one byte. Returns 1 when the byte completes a
	// token (or breaks one), with the token in tok.
	function automatic bit decode_byte(input byte_item_t it, output token_item_t tok);
		logic [7:0]  b;
		logic [31:0] v;
		logic [3:0]  hi_n;
		logic [3:0]  lo_n;
		bit          emit;
		b    = it.data_byte;
		tok  = '0;
		emit = 1'b0;
		case (pm_mode)
			MODE_IDLE: begin
				if (b <= BYTE_OP_MAX && b != BYTE_ESCAPE) begin
					tok.token_kind = KIND_OPERATOR;
					tok.op_code    = b;
					emit           = 1'b1;
				end else if (b >= BYTE_INT1_MIN && b <= BYTE_INT1_MAX) begin
					tok.token_kind = KIND_INTEGER;
					tok.int_value  = {24'd0, b} - INT1_BIAS;
					emit           = 1'b1;
				end else if (b == BYTE_ESCAPE) begin
					pm_mode = MODE_ESC;
				end else if (b == BYTE_SHORT_INT) begin
					pm_mode  = MODE_SHORT;
					pm_left  = 2'd1;
					pm_accum = 32'd0;
				end else if (b == BYTE_LONG_INT) begin
					pm_mode  = MODE_LONG;
					pm_left  = 2'd3;
					pm_accum = 32'd0;
				end else if (b == BYTE_REAL) begin
					pm_mode     = MODE_REAL;
					pm_nibbles  = 64'd0;
					pm_count    = 5'd0;
					pm_overflow = 1'b0;
				end else if (b >= BYTE_POS_MIN && b <= BYTE_POS_MAX) begin
					pm_mode  = MODE_POS;
					pm_accum = {24'd0, b - BYTE_POS_MIN};
				end else if (b >= BYTE_NEG_MIN && b <= BYTE_NEG_MAX) begin
					pm_mode  = MODE_NEG;
					pm_accum = {24'd0, b - BYTE_NEG_MIN};
				end else begin
					tok.token_kind = KIND_MALFORMED;
					emit           = 1'b1;
				end
			end
			MODE_ESC: begin
				parser_to_idle();
				tok.token_kind = KIND_OPERATOR;
				tok.escaped_op = 1'b1;
				tok.op_code    = b;
				emit           = 1'b1;
			end
			MODE_SHORT, MODE_LONG: begin
				pm_accum = {pm_accum[23:0], b};
				if (pm_left == 2'd0) begin
					v = pm_accum;
					if (pm_mode == MODE_SHORT)
						v = {{16{pm_accum[15]}}, pm_accum[15:0]};
					parser_to_idle();
					tok.token_kind = KIND_INTEGER;
					tok.int_value  = v;
					emit           = 1'b1;
				end else begin
					pm_left = pm_left - 2'd1;
				end
			end
			MODE_POS, MODE_NEG: begin
				v = pm_accum * 32'd256 + {24'd0, b} + INT2_BIAS;
				if (pm_mode == MODE_NEG)
					v = 32'd0 - v;
				parser_to_idle();
				tok.token_kind = KIND_INTEGER;
				tok.int_value  = v;
				emit           = 1'b1;
			end
			MODE_REAL: begin
				hi_n = b[7:4];
				lo_n = b[3:0];
				// A terminator in the high nibble hides whatever the low one holds.
				if (hi_n != NIBBLE_END) begin
					keep_nibble(hi_n);
					if (lo_n != NIBBLE_END)
						keep_nibble(lo_n);
				end
				if (hi_n == NIBBLE_END || lo_n == NIBBLE_END) begin
					tok.token_kind    = KIND_REAL;
					tok.real_nibbles  = pm_nibbles;
					tok.real_count    = pm_count;
					tok.real_overflow = pm_overflow;
					parser_to_idle();
					emit = 1'b1;
				end
			end
			default: parser_to_idle();
		endcase
		if (emit) begin
			tok.dict_end = it.last_byte;
		end else if (it.last_byte) begin
			// The DICT ended in the middle of a token.
			parser_to_idle();
			tok.token_kind = KIND_MALFORMED;
			tok.dict_end   = 1'b1;
			emit           = 1'b1;
		end
		return emit;
	endfunction

	// ------------------------------------------------------------------
	// Sender side.
	// ------------------------------------------------------------------

	// Mostly back-to-back, now and then a short gap, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic byte_item_t make_byte(input logic [7:0] b, input logic last);
		byte_item_t it;
		it.data_byte = b;
		it.last_byte = last;
		return it;
	endfunction

	// Offers one byte and returns at the edge where the transfer happened.
	// Valid stays high when the next byte follows without a gap, so the
	// payload simply changes after the accepting edge.
	task automatic send_byte(input byte_item_t it);
		int          gap;
		token_item_t tok;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		if (decode_byte(it, tok))
			expected_tokens.push_back(tok);
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		bytes_sent++;
	endtask

	// Sender goes quiet until every predicted token has been taken. The
	// first wait keeps valid from being lowered and raised in one step.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
	endtask

	// Builds one random token as a byte sequence. Most are well formed with
	// random content; a few are reserved bytes, plain noise, or get cut off
	// by an early end of DICT.
	task automatic send_random_token();
		logic [7:0] seq[$];
		int         pick;
		int         k;
		int         nnib;
		int         cut;
		bit         end_flag;
		logic [3:0] hi_n;
		logic [3:0] lo_n;
		logic [7:0] rb;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			k = $urandom_range(0, 20);
			if (k >= BYTE_ESCAPE)
				k++;
			seq.push_back(8'(k));
		end else if (pick < 18) begin
			seq.push_back(BYTE_ESCAPE);
			seq.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 32) begin
			seq.push_back(8'($urandom_range(BYTE_INT1_MIN, BYTE_INT1_MAX)));
		end else if (pick < 42) begin
			seq.push_back(8'($urandom_range(BYTE_POS_MIN, BYTE_POS_MAX)));
			seq.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 52) begin
			seq.push_back(8'($urandom_range(BYTE_NEG_MIN, BYTE_NEG_MAX)));
			seq.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 62) begin
			seq.push_back(BYTE_SHORT_INT);
			repeat (2) seq.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 72) begin
			seq.push_back(BYTE_LONG_INT);
			repeat (4) seq.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 90) begin
			// Real: usually short, sometimes longer than the nibble store.
			seq.push_back(BYTE_REAL);
			nnib = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 8);
			for (k = 0; k + 1 < nnib; k += 2) begin
				hi_n = 4'($urandom_range(0, 14));
				lo_n = 4'($urandom_range(0, 14));
				seq.push_back({hi_n, lo_n});
			end
			if (nnib % 2) begin
				hi_n = 4'($urandom_range(0, 14));
				seq.push_back({hi_n, NIBBLE_END});
			end else begin
				lo_n = 4'($urandom_range(0, 15));
				seq.push_back({NIBBLE_END, lo_n});
			end
		end else if (pick < 95) begin
			k = $urandom_range(0, 7);
			if (k < 6)
				rb = BYTE_RSV_LO + k[7:0];
			else
				rb = (k == 6) ? BYTE_RSV_31 : BYTE_RSV_FF;
			seq.push_back(rb);
		end else begin
			seq.push_back(8'($urandom_range(0, 255)));
		end

		cut = seq.size() - 1;
		if (seq.size() > 1 && $urandom_range(0, 15) == 0) begin
			cut      = $urandom_range(0, seq.size() - 2);
			end_flag = 1'b1;
		end else begin
			end_flag = ($urandom_range(0, 7) == 0);
		end
		for (k = 0; k <= cut; k++)
			send_byte(make_byte(seq[k], (k == cut) ? end_flag : 1'b0));
	endtask

	// ------------------------------------------------------------------
	// Receiver side: random stalls, plus a long hold-off on request.
	// ------------------------------------------------------------------
	initial begin
		token_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				token_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				token_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				token_stall <= 1'b1;
				repeat (1 + pick_gap()) @(posedge clk);
				token_stall <= 1'b0;
			end else begin
				token_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Token checker.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Outputs are sampled at the edge, so they carry the values that the
	// transfer actually moved.
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("token transfer with nothing expected, kind %0d",
					token_item.token_kind);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("token_kind", 64'(want.token_kind),
					64'(token_item.token_kind));
				check_field("escaped_op", 64'(want.escaped_op),
					64'(token_item.escaped_op));
				check_field("op_code", 64'(want.op_code), 64'(token_item.op_code));
				check_field("int_value", {32'd0, want.int_value},
					{32'd0, token_item.int_value});
				check_field("real_nibbles", want.real_nibbles, token_item.real_nibbles);
				check_field("real_count", 64'(want.real_count),
					64'(token_item.real_count));
				check_field("real_overflow", 64'(want.real_overflow),
					64'(token_item.real_overflow));
				check_field("dict_end", 64'(want.dict_end), 64'(token_item.dict_end));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Lowest and highest single-byte operators, and escaped operators with
	// both extremes of the second byte.
	task automatic test_operators();
		send_byte(make_byte(8'd0, 1'b0));
		send_byte(make_byte(BYTE_OP_MAX, 1'b0));
		send_byte(make_byte(BYTE_ESCAPE, 1'b0));
		send_byte(make_byte(8'h00, 1'b0));
		send_byte(make_byte(BYTE_ESCAPE, 1'b0));
		send_byte(make_byte(8'hff, 1'b0));
	endtask

	// Edges of each integer encoding.
	task automatic test_integers();
		send_byte(make_byte(BYTE_INT1_MIN, 1'b0));
		send_byte(make_byte(BYTE_INT1_MAX, 1'b0));
		send_byte(make_byte(BYTE_POS_MAX, 1'b0));
		send_byte(make_byte(8'hff, 1'b0));
		send_byte(make_byte(BYTE_NEG_MAX, 1'b0));
		send_byte(make_byte(8'hff, 1'b0));
		// Most negative 16-bit short form.
		send_byte(make_byte(BYTE_SHORT_INT, 1'b0));
		send_byte(make_byte(8'h80, 1'b0));
		send_byte(make_byte(8'h00, 1'b0));
		// Most positive 32-bit long form.
		send_byte(make_byte(BYTE_LONG_INT, 1'b0));
		repeat (1) send_byte(make_byte(8'h7f, 1'b0));
		repeat (3) send_byte(make_byte(8'hff, 1'b0));
	endtask

	task automatic test_reals();
		int k;
		// Empty real, the terminator in the high nibble with a live low nibble.
		send_byte(make_byte(BYTE_REAL, 1'b0));
		send_byte(make_byte({NIBBLE_END, 4'h5}, 1'b0));
		// One nibble, terminator in the low nibble.
		send_byte(make_byte(BYTE_REAL, 1'b0));
		send_byte(make_byte({4'ha, NIBBLE_END}, 1'b0));
		// Seventeen nibbles: the store fills and the last one is dropped.
		send_byte(make_byte(BYTE_REAL, 1'b0));
		for (k = 0; k < 8; k++)
			send_byte(make_byte({k[3:0], 4'he - k[3:0]}, 1'b0));
		send_byte(make_byte({4'h5, NIBBLE_END}, 1'b0));
	endtask

	task automatic test_malformed();
		send_byte(make_byte(BYTE_RSV_LO, 1'b0));
		send_byte(make_byte(BYTE_RSV_HI, 1'b0));
		send_byte(make_byte(BYTE_RSV_31, 1'b0));
		send_byte(make_byte(BYTE_RSV_FF, 1'b0));
		// A long integer cut short by the end of the DICT.
		send_byte(make_byte(BYTE_LONG_INT, 1'b0));
		send_byte(make_byte(8'h01, 1'b1));
		// A complete operator carrying the end of the DICT.
		send_byte(make_byte(8'd17, 1'b1));
	endtask

	// The receiver holds off for a long stretch while bytes keep coming
	// back to back, so the pipeline fills and the input stalls. Afterwards
	// the sender waits for every token before going on.
	task automatic test_backpressure();
		int start;
		rx_idle_on = 1'b0;
		tx_idle_on = 1'b0;
		hold_len   = 60;
		start      = bytes_sent;
		while (bytes_sent - start < 40)
			send_random_token();
		wait_drained();
	endtask

	task automatic test_random(input int n_bytes, input bit tx_idle, input bit rx_idle);
		int start;
		tx_idle_on = tx_idle;
		rx_idle_on = rx_idle;
		start      = bytes_sent;
		while (bytes_sent - start < n_bytes)
			send_random_token();
		wait_drained();
	endtask

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_item  = '0;
		parser_to_idle();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_operators();
		test_integers();
		test_reals();
		test_malformed();
		wait_drained();
		test_backpressure();
		test_random(250, 1'b1, 1'b1);
		test_random(250, 1'b0, 1'b0);
		test_random(250, 1'b1, 1'b0);
		test_random(250, 1'b0, 1'b1);

		// Let any stray token show up before the verdict.
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/cdtd_pkg.sv
rtl/cdtd_parser.sv
rtl/cff_dict_token_decoder.sv
tb/sv/tb_cff_dict_token_decoder.sv
